/* src/bmh_pkg.sv */
// Shared types and constants for the binary min-heap block.
// Used by binary_min_heap; no dependencies.
package bmh_pkg;

  // Heap geometry
  localparam int CAPACITY = 128;
  localparam int KEY_W    = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHILD_W  = IDX_W + 1;

  // Stream field widths
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 48;

  typedef logic        [IDX_W-1:0]   idx_t;
  typedef logic        [CNT_W-1:0]   cnt_t;
  typedef logic        [CHILD_W-1:0] child_t;
  typedef logic        [CHILD_W:0]   child_ext_t;
  typedef logic signed [KEY_W-1:0]   key_t;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd3;

endpackage

/* src/bmh_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/binary_min_heap.sv */
// Binary min-heap priority queue: insert, remove minimum, remove at position.
// Depends on bmh_pkg and bmh_ram (two mirrored copies of the heap array).
//
//  channel  | dir | fields (tdata, lowest bit first)
//  s_axis   | in  | command[1:0], key_in[33:2], position[40:34]
//  m_axis   | out | status[1:0], key_out[33:2], count[41:34]
//
// One command at a time: the input is ready only between commands. A command
// passes through decode and write-back, plus one RAM read and one compare and
// shift for each heap level that a sift walks. The result waits in an output
// register; while it is stalled the block holds.
// Reset clears the entry count; the heap array itself is not cleared.
module binary_min_heap (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // command[1:0], key_in[33:2], position[40:34], zero fill
  input  logic [bmh_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status[1:0], key_out[33:2], count[41:34], zero fill
  output logic [bmh_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_TAKE     = 3'd1;
  localparam logic [2:0] ST_LIFT_RD  = 3'd2;
  localparam logic [2:0] ST_LIFT_CMP = 3'd3;
  localparam logic [2:0] ST_SINK_RD  = 3'd4;
  localparam logic [2:0] ST_SINK_CMP = 3'd5;
  localparam logic [2:0] ST_WRITE    = 3'd6;
  localparam logic [2:0] ST_FINISH   = 3'd7;

  logic [2:0]                      state_q, state_d;
  bmh_pkg::idx_t                   at_q, at_d;
  bmh_pkg::key_t                   moving_q, moving_d;
  bmh_pkg::cnt_t                   count_q, count_d;
  logic                            ins_q, ins_d;
  logic                            moved_q, moved_d;
  logic                            has_right_q, has_right_d;
  logic [bmh_pkg::STATUS_W-1:0]    res_status_q, res_status_d;
  bmh_pkg::key_t                   res_key_q, res_key_d;

  logic                            out_valid_q, out_valid_d;
  logic [bmh_pkg::STATUS_W-1:0]    out_status_q;
  bmh_pkg::key_t                   out_key_q;
  bmh_pkg::cnt_t                   out_count_q;
  logic                            out_load;

  // RAM access
  logic                            ram_we;
  bmh_pkg::idx_t                   ram_waddr;
  bmh_pkg::key_t                   ram_wdata;
  bmh_pkg::idx_t                   raddr_a, raddr_b;
  bmh_pkg::key_t                   rdata_a, rdata_b;

  // Input item fields
  logic [bmh_pkg::CMD_W-1:0]       in_command;
  bmh_pkg::key_t                   in_key;
  bmh_pkg::idx_t                   in_position;
  logic                            in_fire;

  // Tree navigation
  bmh_pkg::idx_t                   parent;
  bmh_pkg::child_t                 child_l;
  bmh_pkg::child_ext_t             child_r;
  bmh_pkg::cnt_t                   count_dec;
  logic                            pick_right;
  bmh_pkg::key_t                   pick_key;
  bmh_pkg::idx_t                   pick_idx;

  assign in_command  = s_axis_tdata[1:0];
  assign in_key      = s_axis_tdata[33:2];
  assign in_position = s_axis_tdata[40:34];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign parent    = (at_q - bmh_pkg::idx_t'(1)) >> 1;
  assign child_l   = {at_q, 1'b1};
  assign child_r   = bmh_pkg::child_ext_t'(child_l) + bmh_pkg::child_ext_t'(1);
  assign count_dec = count_q - bmh_pkg::cnt_t'(1);

  // Smaller child; the right one wins only when strictly smaller
  assign pick_right = has_right_q && ($signed(rdata_b) < $signed(rdata_a));
  assign pick_key   = pick_right ? rdata_b : rdata_a;
  assign pick_idx   = pick_right ? child_r[bmh_pkg::IDX_W-1:0] : child_l[bmh_pkg::IDX_W-1:0];

  // Two mirrored heap copies: same writes, independent reads
  bmh_ram #(
    .WIDTH(bmh_pkg::KEY_W),
    .DEPTH(bmh_pkg::CAPACITY)
  ) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(raddr_a),
    .rdata_o(rdata_a)
  );

  bmh_ram #(
    .WIDTH(bmh_pkg::KEY_W),
    .DEPTH(bmh_pkg::CAPACITY)
  ) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(raddr_b),
    .rdata_o(rdata_b)
  );

  // Sequence one command through decode, lift and sink
  always_comb begin
    state_d      = state_q;
    at_d         = at_q;
    moving_d     = moving_q;
    count_d      = count_q;
    ins_d        = ins_q;
    moved_d      = moved_q;
    has_right_d  = has_right_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    ram_we       = 1'b0;
    ram_waddr    = at_q;
    ram_wdata    = moving_q;
    raddr_a      = '0;
    raddr_b      = '0;
    out_load     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_key_d    = '0;
          res_status_d = bmh_pkg::STAT_OK;
          moved_d      = 1'b0;
          ins_d        = 1'b0;
          case (in_command)
            bmh_pkg::CMD_INSERT: begin
              if (count_q == bmh_pkg::cnt_t'(bmh_pkg::CAPACITY)) begin
                res_status_d = bmh_pkg::STAT_FULL;
                state_d      = ST_FINISH;
              end else begin
                at_d     = count_q[bmh_pkg::IDX_W-1:0];
                moving_d = in_key;
                count_d  = count_q + bmh_pkg::cnt_t'(1);
                ins_d    = 1'b1;
                state_d  = ST_LIFT_RD;
              end
            end
            bmh_pkg::CMD_POP: begin
              if (count_q == '0) begin
                res_status_d = bmh_pkg::STAT_EMPTY;
                state_d      = ST_FINISH;
              end else begin
                at_d    = '0;
                raddr_a = '0;
                raddr_b = count_dec[bmh_pkg::IDX_W-1:0];
                count_d = count_dec;
                state_d = ST_TAKE;
              end
            end
            bmh_pkg::CMD_REMOVE: begin
              if (count_q == '0) begin
                res_status_d = bmh_pkg::STAT_EMPTY;
                state_d      = ST_FINISH;
              end else if (bmh_pkg::cnt_t'(in_position) >= count_q) begin
                res_status_d = bmh_pkg::STAT_BADPOS;
                state_d      = ST_FINISH;
              end else begin
                at_d    = in_position;
                raddr_a = in_position;
                raddr_b = count_dec[bmh_pkg::IDX_W-1:0];
                count_d = count_dec;
                state_d = ST_TAKE;
              end
            end
            default: begin
              res_status_d = bmh_pkg::STAT_BADPOS;
              state_d      = ST_FINISH;
            end
          endcase
        end
      end

      // Capture the removed key and the last entry that fills the hole
      ST_TAKE: begin
        res_key_d = rdata_a;
        moving_d  = rdata_b;
        if (bmh_pkg::cnt_t'(at_q) == count_q) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_LIFT_RD;
        end
      end

      // Fetch the parent, or end the lift at the root
      ST_LIFT_RD: begin
        raddr_a = parent;
        if (at_q == '0) begin
          state_d = (ins_q || moved_q) ? ST_WRITE : ST_SINK_RD;
        end else begin
          state_d = ST_LIFT_CMP;
        end
      end

      // Move a larger parent down into the hole
      ST_LIFT_CMP: begin
        if ($signed(rdata_a) > $signed(moving_q)) begin
          ram_we    = 1'b1;
          ram_waddr = at_q;
          ram_wdata = rdata_a;
          at_d      = parent;
          moved_d   = 1'b1;
          state_d   = ST_LIFT_RD;
        end else begin
          state_d = (ins_q || moved_q) ? ST_WRITE : ST_SINK_RD;
        end
      end

      // Fetch both children, or stop at a leaf
      ST_SINK_RD: begin
        raddr_a     = child_l[bmh_pkg::IDX_W-1:0];
        raddr_b     = child_r[bmh_pkg::IDX_W-1:0];
        has_right_d = child_r < bmh_pkg::child_ext_t'(count_q);
        if (child_l >= bmh_pkg::child_t'(count_q)) begin
          state_d = ST_WRITE;
        end else begin
          state_d = ST_SINK_CMP;
        end
      end

      // Move a smaller child up into the hole
      ST_SINK_CMP: begin
        if ($signed(pick_key) < $signed(moving_q)) begin
          ram_we    = 1'b1;
          ram_waddr = at_q;
          ram_wdata = pick_key;
          at_d      = pick_idx;
          state_d   = ST_SINK_RD;
        end else begin
          state_d = ST_WRITE;
        end
      end

      // Drop the moving key into its final slot
      ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = at_q;
        ram_wdata = moving_q;
        state_d   = ST_FINISH;
      end

      // Hand the result to the output register once it is free
      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, clear when the item is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    at_q         <= at_d;
    moving_q     <= moving_d;
    ins_q        <= ins_d;
    moved_q      <= moved_d;
    has_right_q  <= has_right_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_key_q    <= res_key_q;
      out_count_q  <= count_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_count_q, out_key_q, out_status_q};

endmodule
